### rtl/lppa_pkg.sv
// ----------------------------------------------------------------------------
// lppa_pkg
// shared types, widths and constants of the light pen position averager
// ----------------------------------------------------------------------------
package lppa_pkg;

    localparam int BEAM_W   = 9;
    localparam int SUM_W    = 13;
    localparam int CNT_W    = 4;
    localparam int MASK_W   = 16;
    localparam int POS_W    = 17;
    localparam int FRAC_W   = 8;
    localparam int BTN_W    = 3;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    // serial divide: one quotient bit per step
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = 4;
    localparam int REM_W      = CNT_W + 1;

    // reset values of the registers
    localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 4'd4;
    localparam logic [MASK_W-1:0] RIGHT_MASK_RST   = 16'h0400;
    localparam logic [MASK_W-1:0] MIDDLE_MASK_RST  = 16'h0100;

    // bit positions in button_bits
    localparam int BTN_RIGHT_BIT  = 1;
    localparam int BTN_MIDDLE_BIT = 2;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_RIGHT_MASK   = 2'd1,
        CFG_MIDDLE_MASK  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DIV_X = 2'd1,
        ST_DIV_Y = 2'd2
    } state_t;

    typedef struct packed {
        logic              beam_latched;
        logic [BEAM_W-1:0] beam_x;
        logic [BEAM_W-1:0] beam_y;
        logic [MASK_W-1:0] pot_inputs;
    } in_beat_t;

    typedef struct packed {
        logic [POS_W-1:0] pen_x;
        logic [POS_W-1:0] pen_y;
        logic             pen_valid;
        logic [BTN_W-1:0] button_bits;
    } out_beat_t;

    // divider control and status
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/lppa_div.sv
// ----------------------------------------------------------------------------
// lppa_div
// restoring serial divider, one quotient bit per cycle, shared by X and Y
// ----------------------------------------------------------------------------
module lppa_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  lppa_pkg::div_req_t req,
    output lppa_pkg::div_rsp_t rsp
);
    import lppa_pkg::*;

    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_W-1:0]     trial;
    logic                 fits;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? CNT_W'(trial - {1'b0, dsr_reg}) : trial[CNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/light_pen_position_averager_top.sv
// ----------------------------------------------------------------------------
// light_pen_position_averager_top
// averages latched light pen positions over a period and reports buttons
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_data  (lppa_pkg::in_beat_t)
//  m_      | out       | m_valid / m_ready    | m_data  (lppa_pkg::out_beat_t)
//  cfg_    | in        | cfg_wr_en            | cfg_addr, cfg_wdata
//
//  a sampling poll, or a smoothing poll with no trigger, leaves the block idle
//  a smoothing poll with triggers runs two 13-step passes of the
//  shared serial divider, X then Y, each followed by a hand-over
//  the result beat is registered at acceptance and shows the next cycle
//  s_ready is low while dividing, or while an untaken result is not drained
//  aresetn is synchronous, active low; no clearing pass is needed
// ----------------------------------------------------------------------------
module light_pen_position_averager_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lppa_pkg::in_beat_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lppa_pkg::out_beat_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [lppa_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [lppa_pkg::CFG_D_W-1:0]  cfg_wdata
);
    import lppa_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  sample_count_reg;
    logic [MASK_W-1:0] right_mask_reg, middle_mask_reg;
    logic [SUM_W-1:0]  sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]  poll_idx_reg, poll_idx_next, tally_reg, tally_next;
    logic [POS_W-1:0]  smooth_x_reg, smooth_x_next, smooth_y_reg, smooth_y_next;
    logic              smooth_valid_reg, smooth_valid_next;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg, m_data_next;
    logic              accept, smoothing;
    logic [BTN_W-1:0]  buttons;
    logic [POS_W-1:0]  quo_pos;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    lppa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // handshake and poll type
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign smoothing = poll_idx_reg >= sample_count_reg;
    assign quo_pos   = {div_rsp.quotient[POS_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

    // active-low button lines under the masks
    always_comb begin
        buttons = '0;
        buttons[BTN_RIGHT_BIT]  = (s_data.pot_inputs & right_mask_reg) == '0;
        buttons[BTN_MIDDLE_BIT] = (s_data.pot_inputs & middle_mask_reg) == '0;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && smoothing && tally_reg != '0) state_next = ST_DIV_X;
            end
            ST_DIV_X: begin
                if (div_rsp.done) state_next = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                if (div_rsp.done) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb begin
        sum_x_next        = sum_x_reg;
        sum_y_next        = sum_y_reg;
        poll_idx_next     = poll_idx_reg;
        tally_next        = tally_reg;
        smooth_x_next     = smooth_x_reg;
        smooth_y_next     = smooth_y_reg;
        smooth_valid_next = smooth_valid_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = sum_x_reg;
        div_req.divisor   = tally_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next            = 1'b1;
                    m_data_next.pen_x       = smooth_x_reg;
                    m_data_next.pen_y       = smooth_y_reg;
                    m_data_next.pen_valid   = smooth_valid_reg;
                    m_data_next.button_bits = buttons;
                    if (smoothing) begin
                        smooth_valid_next = tally_reg >= (sample_count_reg >> 1);
                        poll_idx_next     = '0;
                        if (tally_reg != '0) begin
                            div_req.start = 1'b1;
                        end else begin
                            smooth_x_next = '0;
                            smooth_y_next = '0;
                            sum_x_next    = '0;
                            sum_y_next    = '0;
                        end
                    end else begin
                        poll_idx_next = poll_idx_reg + 1'b1;
                        if (s_data.beam_latched) begin
                            tally_next = tally_reg + 1'b1;
                            sum_x_next = sum_x_reg + SUM_W'(s_data.beam_x);
                            sum_y_next = sum_y_reg + SUM_W'(s_data.beam_y);
                        end
                    end
                end
            end
            ST_DIV_X: begin
                if (div_rsp.done) begin
                    smooth_x_next    = quo_pos;
                    div_req.start    = 1'b1;
                    div_req.dividend = sum_y_reg;
                end
            end
            ST_DIV_Y: begin
                if (div_rsp.done) begin
                    smooth_y_next = quo_pos;
                    sum_x_next    = '0;
                    sum_y_next    = '0;
                    tally_next    = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            right_mask_reg   <= RIGHT_MASK_RST;
            middle_mask_reg  <= MIDDLE_MASK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[CNT_W-1:0];
                CFG_RIGHT_MASK:   right_mask_reg   <= cfg_wdata[MASK_W-1:0];
                CFG_MIDDLE_MASK:  middle_mask_reg  <= cfg_wdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // averaging state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            poll_idx_reg     <= '0;
            tally_reg        <= '0;
            smooth_x_reg     <= '0;
            smooth_y_reg     <= '0;
            smooth_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            sum_x_reg        <= sum_x_next;
            sum_y_reg        <= sum_y_next;
            poll_idx_reg     <= poll_idx_next;
            tally_reg        <= tally_next;
            smooth_x_reg     <= smooth_x_next;
            smooth_y_reg     <= smooth_y_next;
            smooth_valid_reg <= smooth_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/lppa_checker.sv
// ----------------------------------------------------------------------------
// lppa_checker
// port-level checks of the light pen position averager, bound to the top
// ----------------------------------------------------------------------------
module lppa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lppa_pkg::out_beat_t m_data
);
    import lppa_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // every accepted poll gives a result the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after accepted poll");

    // no poll is taken while an untaken result would be overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input ready while result register blocked");

    // position is a whole average shifted up, bit 0 of buttons unused
    a_result_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pen_x[FRAC_W-1:0] == '0) &&
                    (m_data.pen_y[FRAC_W-1:0] == '0) && !m_data.button_bits[0])
        else $error("malformed result beat");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind light_pen_position_averager_top lppa_checker u_lppa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
